>>> design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared field widths, request and status codes, and the transfer payload
// types used by the allocator and its submodules.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Field widths of one request and one response.
    localparam int TYPE_W   = 2;
    localparam int PAGE_W   = 20;
    localparam int COUNT_W  = 21;
    localparam int STATUS_W = 2;

    // Request codes.
    localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_MARK  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ALLOC = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd2;

    // One past the largest page number a response can carry.
    localparam logic [COUNT_W-1:0] PAGE_LIMIT = 21'h100000;

    // Request payload.
    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [PAGE_W-1:0]  start_page;
        logic [COUNT_W-1:0] end_page;
    } t_req;

    // Response payload.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page_number;
        logic [COUNT_W-1:0]  free_pages;
    } t_rsp;

endpackage

>>> design/bpa_ram.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator RAM
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/bpa_divider.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator page splitter
// Splits a page number into a bitmap word index and a bit position. The word
// size is a power of two, so the split is a plain bit slice.
// ----------------------------------------------------------------------------
module bpa_divider #(
    parameter  int DIVISOR = 32,
    localparam int REM_W   = $clog2(DIVISOR)
) (
    input  logic [bpa_pkg::PAGE_W-1:0]       i_dividend,
    output logic [bpa_pkg::PAGE_W-REM_W-1:0] o_quotient,
    output logic [REM_W-1:0]                 o_remainder
);

    // Upper bits select the word, lower bits the position inside it.
    assign o_quotient  = i_dividend[bpa_pkg::PAGE_W-1:REM_W];
    assign o_remainder = i_dividend[REM_W-1:0];

endmodule

>>> design/bitmap_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit physical page allocator over a one-bit-per-page usage bitmap
// held in a synchronous RAM.
// ----------------------------------------------------------------------------
// The block handles one request at a time. After reset it runs a clearing
// pass that marks every page used; no request is taken until it ends. A
// free or mark request first splits the page number into word and bit,
// then reads the word, modifies and writes it back, and hands over the
// response; the next request can be taken in the cycle after the hand-over.
// An allocate request splits the start page and then scans the bitmap; the
// scan reads one word per cycle from the RAM's single read port. Requests
// that are out of range, empty searches and unknown request types go
// straight to the hand-over. The hand-over waits while an earlier response
// has not yet been transferred, and a new request is taken while a finished
// response still waits on the response channel.
module bitmap_page_allocator_unit #(
    parameter int BITMAP_WORDS  = 32768,
    parameter int BITS_PER_WORD = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  bpa_pkg::t_req   i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output bpa_pkg::t_rsp   o_rsp
);

    localparam int WORD_AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int BIT_W   = $clog2(BITS_PER_WORD);
    localparam int BASE_W  = bpa_pkg::PAGE_W + 2;
    localparam int TOTAL   = BITMAP_WORDS * BITS_PER_WORD;

    localparam logic [BASE_W-1:0]           TOTAL_W   = BASE_W'(TOTAL);
    localparam logic [bpa_pkg::COUNT_W-1:0] END_LIMIT =
        (TOTAL < int'(bpa_pkg::PAGE_LIMIT)) ? bpa_pkg::COUNT_W'(TOTAL)
                                             : bpa_pkg::PAGE_LIMIT;
    localparam logic [WORD_AW-1:0]          LAST_WORD = WORD_AW'(BITMAP_WORDS - 1);

    // Sequencer states.
    localparam logic [2:0] ST_CLR     = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_DIV     = 3'd2;
    localparam logic [2:0] ST_RMW_RD  = 3'd3;
    localparam logic [2:0] ST_RMW     = 3'd4;
    localparam logic [2:0] ST_SCAN_RD = 3'd5;
    localparam logic [2:0] ST_SCAN    = 3'd6;
    localparam logic [2:0] ST_FIN     = 3'd7;

    logic [2:0]                     r_state,  n_state;
    logic [WORD_AW-1:0]             r_clr,    n_clr;
    logic [bpa_pkg::TYPE_W-1:0]     r_type,   n_type;
    logic [bpa_pkg::PAGE_W-1:0]     r_start,  n_start;
    logic [bpa_pkg::COUNT_W-1:0]    r_end,    n_end;
    logic [WORD_AW-1:0]             r_addr,   n_addr;
    logic [BIT_W-1:0]               r_bit,    n_bit;
    logic [BASE_W-1:0]              r_base,   n_base;
    logic                           r_first,  n_first;
    logic [bpa_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [bpa_pkg::PAGE_W-1:0]     r_page,   n_page;
    logic [bpa_pkg::COUNT_W-1:0]    r_count,  n_count;
    logic                           r_rsp_valid, n_rsp_valid;
    bpa_pkg::t_rsp                  r_rsp,    n_rsp;

    // RAM ports.
    logic                           w_we;
    logic [WORD_AW-1:0]             w_waddr;
    logic [BITS_PER_WORD-1:0]       w_wdata;
    logic [WORD_AW-1:0]             w_raddr;
    logic [BITS_PER_WORD-1:0]       w_q;

    // Page split ports.
    logic [bpa_pkg::PAGE_W-BIT_W-1:0] w_quo;
    logic [BIT_W-1:0]               w_rem;

    // Request decode and word evaluation.
    logic [bpa_pkg::COUNT_W-1:0]    w_end_clip;
    logic [BITS_PER_WORD-1:0]       w_avail;
    logic [BITS_PER_WORD-1:0]       w_low;
    logic                           w_hit;
    logic [BIT_W-1:0]               w_k;
    logic [BASE_W-1:0]              w_found;
    logic                           w_found_ok;
    logic [BASE_W-1:0]              w_next_base;
    logic                           w_next_past;
    logic [BITS_PER_WORD-1:0]       w_bit_mask;
    logic                           w_set;
    logic                           w_flip;

    bpa_ram #(
        .WIDTH (BITS_PER_WORD),
        .DEPTH (BITMAP_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    bpa_divider #(
        .DIVISOR (BITS_PER_WORD)
    ) u_divider (
        .i_dividend  (r_start),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Clip the search end to the bitmap size and the largest reportable page.
    assign w_end_clip = (i_req.end_page > END_LIMIT) ? END_LIMIT : i_req.end_page;

    // Free pages in the word under evaluation; the first word ignores bits
    // below the start page.
    always_comb begin
        for (int i = 0; i < BITS_PER_WORD; i++) begin
            w_avail[i] = ~w_q[i] & (~r_first | (BIT_W'(i) >= r_bit));
        end
        w_hit = |w_avail;
        w_low = w_avail & (~w_avail + 1'b1);
        w_k   = '0;
        for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
            if (w_avail[i]) begin
                w_k = BIT_W'(i);
            end
        end
    end

    assign w_found     = r_base + BASE_W'(w_k);
    assign w_found_ok  = (w_found < {1'b0, r_end});
    assign w_next_base = r_base + BASE_W'(BITS_PER_WORD);
    assign w_next_past = (w_next_base >= {1'b0, r_end});

    // Single-bit update for free and mark requests.
    assign w_bit_mask = BITS_PER_WORD'(1) << r_bit;
    assign w_set      = (r_type == bpa_pkg::REQ_MARK);
    assign w_flip     = (w_q[r_bit] != w_set);

    // Sequencer next state and RAM access.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_type      = r_type;
        n_start     = r_start;
        n_end       = r_end;
        n_addr      = r_addr;
        n_bit       = r_bit;
        n_base      = r_base;
        n_first     = r_first;
        n_status    = r_status;
        n_page      = r_page;
        n_count     = r_count;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid & ~i_rsp_ready;

        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = w_q;
        w_raddr     = r_addr;

        unique case (r_state)
            ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '1;
                n_clr   = r_clr + 1'b1;
                if (r_clr == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_type   = i_req.req_type;
                    n_start  = i_req.start_page;
                    n_end    = w_end_clip;
                    n_status = bpa_pkg::STAT_DONE;
                    n_page   = '0;
                    unique case (i_req.req_type)
                        bpa_pkg::REQ_FREE, bpa_pkg::REQ_MARK: begin
                            // Pages beyond the bitmap are ignored.
                            if ({2'b00, i_req.start_page} >= TOTAL_W) begin
                                n_state = ST_FIN;
                            end else begin
                                n_state = ST_DIV;
                            end
                        end
                        bpa_pkg::REQ_ALLOC: begin
                            if ({1'b0, i_req.start_page} >= w_end_clip) begin
                                n_status = bpa_pkg::STAT_NONE;
                                n_state  = ST_FIN;
                            end else begin
                                n_state = ST_DIV;
                            end
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // Split the registered start page into word and bit.
                n_addr  = WORD_AW'(w_quo);
                n_bit   = w_rem;
                n_base  = {2'b00, r_start} - BASE_W'(w_rem);
                n_state = (r_type == bpa_pkg::REQ_ALLOC) ? ST_SCAN_RD : ST_RMW_RD;
            end
            ST_RMW_RD: begin
                n_state = ST_RMW;
            end
            ST_RMW: begin
                if (w_flip) begin
                    w_we    = 1'b1;
                    w_wdata = w_set ? (w_q | w_bit_mask) : (w_q & ~w_bit_mask);
                    n_count = w_set ? (r_count - 1'b1) : (r_count + 1'b1);
                end
                n_state = ST_FIN;
            end
            ST_SCAN_RD: begin
                n_first = 1'b1;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // Read the next word ahead while this one is evaluated.
                w_raddr = r_addr + 1'b1;
                if (w_hit) begin
                    if (w_found_ok) begin
                        w_we     = 1'b1;
                        w_wdata  = w_q | w_low;
                        n_count  = r_count - 1'b1;
                        n_status = bpa_pkg::STAT_ALLOC;
                        n_page   = w_found[bpa_pkg::PAGE_W-1:0];
                    end else begin
                        n_status = bpa_pkg::STAT_NONE;
                    end
                    n_state = ST_FIN;
                end else if (w_next_past) begin
                    n_status = bpa_pkg::STAT_NONE;
                    n_state  = ST_FIN;
                end else begin
                    n_base  = w_next_base;
                    n_addr  = r_addr + 1'b1;
                    n_first = 1'b0;
                end
            end
            ST_FIN: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp.status      = r_status;
                    n_rsp.page_number = r_page;
                    n_rsp.free_pages  = r_count;
                    n_rsp_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Request and response payload.
    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_start  <= n_start;
        r_end    <= n_end;
        r_addr   <= n_addr;
        r_bit    <= n_bit;
        r_base   <= n_base;
        r_first  <= n_first;
        r_status <= n_status;
        r_page   <= n_page;
        r_rsp    <= n_rsp;
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // No request transfer is possible while the bitmap is being cleared.
    a_no_req_in_clear: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !o_req_ready
    ) else $error("request ready during clearing pass");

    // The free-page count only moves together with a bitmap write outside clearing.
    a_count_with_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |->
            $past(w_we && (r_state != ST_CLR))
    ) else $error("free-page count changed without a bitmap write");

    // An allocated page lies below the limit that search ends are clipped to.
    a_alloc_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == bpa_pkg::STAT_ALLOC)) |->
            ({1'b0, o_rsp.page_number} < END_LIMIT)
    ) else $error("allocated page beyond the page limit");

    // A waiting response stays valid and unchanged until it is transferred.
    a_rsp_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp))
    ) else $error("response changed while waiting for transfer");

endmodule
